/* rtl/ecr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the quarter-sine generator for the crossfade router.
// No dependencies; ecr_divider, ecr_ctrl, ecr_datapath and the top level import this package.
package ecr_pkg;

   localparam int SampleWidth = 24;
   localparam int SelectWidth = 7;
   localparam int IndexWidth  = 6;
   localparam int CountWidth  = 16;
   localparam int GainWidth   = 16;
   localparam int ProdWidth   = SampleWidth + GainWidth + 1;

   localparam longint unsigned HalfPiQ30 = 64'd1686629713;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic [SelectWidth-1:0]        select;
   } req_payload_type;

   typedef struct packed {
      logic [IndexWidth-1:0]         out_index;
      logic signed [SampleWidth-1:0] value;
      logic                          last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_MULTIPLY,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic                  load_item;
      logic                  ram_read;
      logic                  update;
      logic                  lookup;
      logic                  multiply;
      logic                  emit;
      logic                  last;
      logic [IndexWidth-1:0] index;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } ctrl_status_type;

   // Unsigned long division by shift and subtract; used only to build constant tables.
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned rem;
      longint unsigned quo;
      rem = 0;
      quo = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // Gain in Q1.15 for table step k of 2^sb; Taylor series in Q30, evaluated at elaboration.
   function automatic logic [GainWidth-1:0] quarter_sine_q15(input longint unsigned k,
                                                            input int unsigned sb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned div;
      longint          sum;
      longint          g;
      x    = (HalfPiQ30 * k) >> sb;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 20; n++) begin
         div  = longint'(2 * n) * longint'(2 * n + 1);
         term = div_u64((term * x2) >> 30, div);
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      g = (sum + 16384) >>> 15;
      if (g > 32768) begin
         g = 32768;
      end
      return GainWidth'(g);
   endfunction

endpackage

/* rtl/ecr_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ecr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ecr_divider.sv */
`timescale 1ns / 1ps
// Serial restoring divider: (count << SINE_TABLE_BITS) / len, saturated to 2^SINE_TABLE_BITS.
// One quotient bit per cycle. Depends on ecr_pkg.
module ecr_divider
   import ecr_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [CountWidth-1:0]    dividend,
   input  logic [CountWidth-1:0]    divisor,
   output logic                     done,
   output logic [SINE_TABLE_BITS:0] quotient
);

   localparam int StepWidth = $clog2(SINE_TABLE_BITS + 1);

   logic                       running_ff, running_in;
   logic                       done_ff, done_in;
   logic [StepWidth-1:0]       step_ff, step_in;
   logic                       sat_ff, sat_in;
   logic [CountWidth:0]        rem_ff, rem_in;
   logic [SINE_TABLE_BITS-1:0] quo_ff, quo_in;
   logic [CountWidth-1:0]      len_ff, len_in;
   logic [CountWidth:0]        rem_shift;
   logic                       fits;

   assign rem_shift = {rem_ff[CountWidth-1:0], 1'b0};
   assign fits      = rem_shift >= {1'b0, len_ff};

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      sat_in     = sat_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      len_in     = len_ff;
      if (start) begin
         running_in = 1'b1;
         step_in    = StepWidth'(SINE_TABLE_BITS);
         sat_in     = dividend >= divisor;
         rem_in     = {1'b0, dividend};
         quo_in     = '0;
         len_in     = divisor;
      end else if (running_ff) begin
         rem_in  = fits ? rem_shift - {1'b0, len_ff} : rem_shift;
         quo_in  = {quo_ff[SINE_TABLE_BITS-2:0], fits};
         step_in = step_ff - StepWidth'(1);
         if (step_ff == StepWidth'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
      end
      step_ff <= step_in;
      sat_ff  <= sat_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      len_ff  <= len_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? (SINE_TABLE_BITS + 1)'(1) << SINE_TABLE_BITS
                            : {1'b0, quo_ff};

endmodule

/* rtl/ecr_ctrl.sv */
`timescale 1ns / 1ps
// Controller: walks each accepted item through all outputs, one phase at a time.
// Depends on ecr_pkg; drives ecr_datapath by command struct.
module ecr_ctrl
   import ecr_pkg::*;
#(
   parameter int NUM_OUTPUTS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type        state_ff, state_in;
   logic [IndexWidth-1:0] index_ff, index_in;
   logic                  at_last;

   assign at_last = index_ff == IndexWidth'(NUM_OUTPUTS - 1);

   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
               index_in = '0;
            end
         end
         ST_READ:     state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP:   state_in = ST_MULTIPLY;
         ST_MULTIPLY: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
                  index_in = index_ff + IndexWidth'(1);
               end
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.index     = index_ff;
      cmd.last      = at_last;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_READ:     cmd.ram_read = 1'b1;
         ST_UPDATE:   cmd.update   = 1'b1;
         ST_DIVIDE:   ;
         ST_LOOKUP:   cmd.lookup   = 1'b1;
         ST_MULTIPLY: cmd.multiply = 1'b1;
         ST_EMIT:     cmd.emit     = status.out_free;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
      end
   end

endmodule

/* rtl/ecr_datapath.sv */
`timescale 1ns / 1ps
// Datapath: fade counter RAM, serial divider, sine table, multiplier and result register.
// Depends on ecr_pkg, ecr_ram and ecr_divider.
module ecr_datapath
   import ecr_pkg::*;
#(
   parameter int NUM_OUTPUTS     = 8,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CountWidth-1:0] csr_wr_data
);

   localparam int AddrWidth = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
   localparam int TableSize = (1 << SINE_TABLE_BITS) + 1;

   logic signed [SampleWidth-1:0] sample_ff;
   logic [SelectWidth-1:0]        choice_ff, choice_in;
   logic [CountWidth-1:0]         fade_len_ff;
   logic [NUM_OUTPUTS-1:0]        valid_ff, valid_in;
   logic [GainWidth-1:0]          gain_ff;
   logic signed [ProdWidth-1:0]   prod_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_payload_type               rsp_data_ff;

   logic [AddrWidth-1:0]          addr;
   logic [CountWidth-1:0]         len;
   logic [CountWidth-1:0]         ram_rd_data;
   logic [CountWidth-1:0]         cur_count;
   logic [CountWidth-1:0]         new_count;
   logic                          active;
   logic                          div_done;
   logic [SINE_TABLE_BITS:0]      quotient;
   logic signed [GainWidth:0]     gain_ext;
   logic signed [ProdWidth-1:0]   rounded;
   logic [GainWidth-1:0]          sine_rom [TableSize];

   for (genvar i = 0; i < TableSize; i++) begin : g_sine
      localparam logic [GainWidth-1:0] StepGain =
         quarter_sine_q15(longint'(i), SINE_TABLE_BITS);
      assign sine_rom[i] = StepGain;
   end

   assign addr      = cmd.index[AddrWidth-1:0];
   assign len       = (fade_len_ff == '0) ? CountWidth'(1) : fade_len_ff;
   assign choice_in = (req_data.select > SelectWidth'(NUM_OUTPUTS))
                      ? SelectWidth'(NUM_OUTPUTS) : req_data.select;

   // Entries never written since reset read as zero.
   assign cur_count = valid_ff[addr] ? ram_rd_data : '0;
   assign active    = choice_ff == ({1'b0, cmd.index} + SelectWidth'(1));

   always_comb begin
      new_count = cur_count;
      if (active && (cur_count < len)) begin
         new_count = cur_count + CountWidth'(1);
      end else if (!active && (cur_count != '0)) begin
         new_count = cur_count - CountWidth'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.update) begin
         valid_in[addr] = 1'b1;
      end
   end

   ecr_ram #(
      .WIDTH (CountWidth),
      .DEPTH (NUM_OUTPUTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (addr),
      .wr_data (new_count),
      .rd_en   (cmd.ram_read),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   ecr_divider #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.update),
      .dividend (new_count),
      .divisor  (len),
      .done     (div_done),
      .quotient (quotient)
   );

   assign gain_ext = signed'({1'b0, gain_ff});
   assign rounded  = (prod_ff + ProdWidth'(16384)) >>> 15;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_len_ff  <= CountWidth'(1);
         choice_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fade_len_ff <= csr_wr_data;
         end
         if (cmd.load_item) begin
            choice_ff <= choice_in;
         end
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_item) begin
         sample_ff <= req_data.sample;
      end
      if (cmd.lookup) begin
         gain_ff <= sine_rom[quotient];
      end
      if (cmd.multiply) begin
         prod_ff <= sample_ff * gain_ext;
      end
      if (cmd.emit) begin
         rsp_data_ff.out_index <= cmd.index;
         rsp_data_ff.value     <= rounded[SampleWidth-1:0];
         rsp_data_ff.last      <= cmd.last;
      end
   end

   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

/* rtl/equal_power_crossfade_router.sv */
`timescale 1ns / 1ps
// Equal-power crossfade router, top level: controller plus datapath.
// Depends on ecr_pkg, ecr_ctrl, ecr_datapath (and through it ecr_ram, ecr_divider).
//
// Usage:
//   req_* takes one item: a signed 24-bit sample and a 1-based output select
//   (0 = none, values above NUM_OUTPUTS act as NUM_OUTPUTS). Each item yields
//   NUM_OUTPUTS items on rsp_*, one per output in index order, each the sample
//   scaled by that output's quarter-sine fade gain; last marks the final one.
//   csr_wr_en/csr_wr_data write the fade length in samples (0 acts as 1);
//   write it only while the block is idle.
// Sequence:
//   Each output steps through these phases in order:
//   read the counter, update it, run the serial divider (one quotient bit per
//   cycle), look up the gain, multiply, load the result register.
//   The next item is accepted while the last result still waits in rsp_data.
// Reset: synchronous; fade length 1, no output selected, all fade counters zero.
// Stall: rsp_ready held low stalls the walk at the result register; nothing drops.
module equal_power_crossfade_router
   import ecr_pkg::*;
#(
   parameter int NUM_OUTPUTS     = 8,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CountWidth-1:0] csr_wr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ecr_ctrl #(
      .NUM_OUTPUTS (NUM_OUTPUTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecr_datapath #(
      .NUM_OUTPUTS     (NUM_OUTPUTS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule
